[hw/rtl/lt_pkg.sv]
// ----------------------------------------------------------------------------
// lt_pkg
// Shared types and constants for the LRU translation buffer: operation codes,
// the token that walks the cell chain and the broadcast write/flush control.
// ----------------------------------------------------------------------------
package lt_pkg;

    localparam int ADDR_W     = 32;
    localparam int STAMP_W    = 32;
    localparam int IDX_W      = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_TABLE_PRESENT = 1'b0;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [STAMP_W-1:0] t_stamp;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_FLUSH  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic   active;
        t_mode  mode;
        logic   look_en;
        t_addr  va;
        t_addr  pa;
        t_stamp stamp;
        logic   found;
        t_addr  xlat;
        t_idx   vic_idx;
        t_stamp vic_stamp;
    } t_tok;

    typedef struct packed {
        logic   flush;
        logic   wr_en;
        t_idx   wr_idx;
        t_addr  va;
        t_addr  pa;
        t_stamp stamp;
    } t_ctrl;

endpackage

[hw/rtl/lt_cell.sv]
// ----------------------------------------------------------------------------
// lt_cell
// One translation entry. Matches and stamps lookups, ranks itself as insert
// victim, and passes the token on to the next cell through its token register.
// ----------------------------------------------------------------------------
module lt_cell #(
    parameter int INDEX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lt_pkg::t_tok  i_tok,
    input  lt_pkg::t_ctrl i_ctrl,
    output lt_pkg::t_tok  o_tok
);
    import lt_pkg::*;

    logic   r_valid;
    t_addr  r_virt;
    t_addr  r_phys;
    t_stamp r_stamp;
    t_tok   r_tok;
    t_tok   n_tok;
    logic   w_match;
    logic   w_pick;

    assign w_match = i_tok.active && i_tok.look_en && !i_tok.found && r_valid &&
                     (r_virt == i_tok.va);
    assign w_pick  = i_tok.active && (i_tok.mode == MODE_INSERT) &&
                     ((INDEX == 0) || !r_valid || (r_stamp < i_tok.vic_stamp));

    always_comb begin
        n_tok = i_tok;
        if (w_match) begin
            n_tok.found = 1'b1;
            n_tok.xlat  = r_phys;
        end
        if (w_pick) begin
            n_tok.vic_idx   = IDX_W'(INDEX);
            n_tok.vic_stamp = r_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.active <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_stamp <= '0;
        end else if (i_ctrl.flush) begin
            r_valid <= 1'b0;
            r_stamp <= '0;
        end else if (i_ctrl.wr_en && (i_ctrl.wr_idx == IDX_W'(INDEX))) begin
            r_valid <= 1'b1;
            r_stamp <= i_ctrl.stamp;
        end else if (w_match) begin
            r_stamp <= i_tok.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en && (i_ctrl.wr_idx == IDX_W'(INDEX))) begin
            r_virt <= i_ctrl.va;
            r_phys <= i_ctrl.pa;
        end
    end

    assign o_tok = r_tok;

endmodule

[hw/rtl/lru_tlb.sv]
// ----------------------------------------------------------------------------
// lru_tlb
// Fully associative translation buffer with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each transfer (lookup, insert or flush) walks a chain of ENTRY_COUNT entry
// cells, one cell per cycle; the chain walk sets the rate while the receiver
// takes results. One operation is in flight at a time; once its result is
// loaded into the output register, the next input is taken while the result
// waits there. An insert writes its victim cell and a flush clears all cells
// in the cycle the token leaves the last cell. Lookups miss while table_present is 0.
// ----------------------------------------------------------------------------
module lru_tlb #(
    parameter int ENTRY_COUNT = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_mode,
    input  logic [lt_pkg::ADDR_W-1:0]      i_virtual_address,
    input  logic [lt_pkg::ADDR_W-1:0]      i_physical_address,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_hit,
    output logic [lt_pkg::ADDR_W-1:0]      o_translated_address
);
    import lt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_table_present;
    t_stamp r_counter;
    t_tok   r_launch;
    t_tok   w_tok [ENTRY_COUNT+1];
    t_tok   w_tail;
    t_ctrl  w_ctrl;
    logic   r_res_hit;
    t_addr  r_res_xlat;
    logic   w_res_hit;
    logic   w_bump;
    logic   r_out_valid;
    logic   r_out_hit;
    t_addr  r_out_xlat;
    logic   w_accept;
    logic   w_out_free;
    logic   w_load;
    logic   w_in_ready;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_present <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_TABLE_PRESENT)) begin
            r_table_present <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TABLE_PRESENT) begin
            prdata[0] = r_table_present;
        end
    end

    // launch
    assign w_accept = i_in_valid && w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch.active <= 1'b0;
        end else begin
            r_launch.active    <= w_accept;
            r_launch.mode      <= t_mode'(i_mode);
            r_launch.look_en   <= (t_mode'(i_mode) == MODE_LOOKUP) && r_table_present;
            r_launch.va        <= i_virtual_address;
            r_launch.pa        <= i_physical_address;
            r_launch.stamp     <= r_counter;
            r_launch.found     <= 1'b0;
            r_launch.xlat      <= '0;
            r_launch.vic_idx   <= '0;
            r_launch.vic_stamp <= '0;
        end
    end

    // cell chain
    assign w_tok[0] = r_launch;

    for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
        lt_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_ctrl  (w_ctrl),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_tail = w_tok[ENTRY_COUNT];

    always_comb begin
        w_ctrl.flush  = w_tail.active && (w_tail.mode == MODE_FLUSH);
        w_ctrl.wr_en  = w_tail.active && (w_tail.mode == MODE_INSERT);
        w_ctrl.wr_idx = w_tail.vic_idx;
        w_ctrl.va     = w_tail.va;
        w_ctrl.pa     = w_tail.pa;
        w_ctrl.stamp  = w_tail.stamp;
    end

    always_comb begin
        case (w_tail.mode)
            MODE_LOOKUP: begin
                w_res_hit = w_tail.found;
                w_bump    = w_tail.found;
            end
            MODE_INSERT: begin
                w_res_hit = 1'b1;
                w_bump    = 1'b1;
            end
            MODE_FLUSH: begin
                w_res_hit = 1'b1;
                w_bump    = 1'b0;
            end
            default: begin
                w_res_hit = 1'b0;
                w_bump    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else if (w_tail.active && w_bump) begin
            r_counter <= r_counter + STAMP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tail.active) begin
            r_res_hit  <= w_res_hit;
            r_res_xlat <= w_tail.found ? w_tail.xlat : '0;
        end
    end

    // control
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_tail.active) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            ST_HOLD: begin
                w_load = w_out_free;
            end
            default: begin
                w_in_ready = 1'b0;
                w_load     = 1'b0;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_hit  <= r_res_hit;
            r_out_xlat <= r_res_xlat;
        end
    end

    assign o_in_ready           = w_in_ready;
    assign o_out_valid          = r_out_valid;
    assign o_hit                = r_out_hit;
    assign o_translated_address = r_out_xlat;

endmodule

[sim/lru_tlb_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_tlb_tb
// Self-checking testbench for the LRU translation buffer. A queue of pending
// operations feeds a valid/ready driver, and a built-in LRU translation
// predictor turns every input transfer into an expected result. A monitor
// compares each output transfer field by field. The table_present register is
// set over the APB port between phases, when the block is idle. Directed
// operations come first, then random lookup/insert/flush traffic over a
// small address pool, with random idling on both sides, one long receiver
// stall and one phase with no idling at all.
// ----------------------------------------------------------------------------
module lru_tlb_tb;
    import lt_pkg::*;

    localparam int          ENTRY_COUNT = 16;
    localparam int          LIMIT       = 500000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          POOL_SIZE   = 24;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] TP_ADDR     = APB_ADDR_W'(4 * REG_TABLE_PRESENT);
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = APB_ADDR_W'(4);

    typedef struct packed {
        logic [1:0] mode;
        t_addr      va;
        t_addr      pa;
    } t_op;

    typedef struct packed {
        logic  hit;
        t_addr xlat;
    } t_xlat_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_mode = '0;
    t_addr                 i_virtual_address = '0;
    t_addr                 i_physical_address = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_hit;
    t_addr                 o_translated_address;

    lru_tlb #(
        .ENTRY_COUNT(ENTRY_COUNT)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_mode(i_mode),
        .i_virtual_address(i_virtual_address),
        .i_physical_address(i_physical_address),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_hit(o_hit),
        .o_translated_address(o_translated_address)
    );

    // predictor state
    logic   tlb_valid [ENTRY_COUNT];
    t_addr  tlb_virt  [ENTRY_COUNT];
    t_addr  tlb_phys  [ENTRY_COUNT];
    t_stamp tlb_stamp [ENTRY_COUNT];
    t_stamp use_count;
    logic   table_on;

    t_op       pending_ops[$];
    t_xlat_res expected_xlat[$];
    t_xlat_res got_exp;
    t_addr     addr_pool [POOL_SIZE];

    int   ops_queued = 0;
    int   ops_taken = 0;
    int   fails = 0;
    int   cycles = 0;
    int   hold_cnt = 0;
    logic in_xfer = 1'b0;
    logic calm = 1'b0;
    logic squeeze = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_xlat_res translate_op(t_op op);
        t_xlat_res r;
        int        victim;
        logic      found;
        r = '0;
        found = 1'b0;
        if (op.mode == MODE_LOOKUP) begin
            if (table_on) begin
                for (int i = 0; i < ENTRY_COUNT; i++) begin
                    if (!found && tlb_valid[i] && tlb_virt[i] == op.va) begin
                        found = 1'b1;
                        r.hit = 1'b1;
                        r.xlat = tlb_phys[i];
                        tlb_stamp[i] = use_count;
                        use_count = use_count + 1;
                    end
                end
            end
        end else if (op.mode == MODE_INSERT) begin
            victim = 0;
            for (int i = 1; i < ENTRY_COUNT; i++) begin
                if (!tlb_valid[i] || tlb_stamp[i] < tlb_stamp[victim]) begin
                    victim = i;
                end
            end
            tlb_valid[victim] = 1'b1;
            tlb_virt[victim] = op.va;
            tlb_phys[victim] = op.pa;
            tlb_stamp[victim] = use_count;
            use_count = use_count + 1;
            r.hit = 1'b1;
        end else if (op.mode == MODE_FLUSH) begin
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                tlb_valid[i] = 1'b0;
                tlb_virt[i] = '0;
                tlb_phys[i] = '0;
                tlb_stamp[i] = '0;
            end
            r.hit = 1'b1;
        end
        return r;
    endfunction

    // monitor: predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else if (!i_rst_n) begin
            in_xfer <= 1'b0;
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                tlb_valid[i] = 1'b0;
                tlb_virt[i] = '0;
                tlb_phys[i] = '0;
                tlb_stamp[i] = '0;
            end
            use_count = '0;
            table_on = 1'b0;
        end else begin
            in_xfer <= i_in_valid && o_in_ready;
            if (psel && penable && pwrite && pready && paddr == TP_ADDR) begin
                table_on = pwdata[0];
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_xlat.size() == 0) begin
                    $error("unexpected result: hit %0d translated_address %h",
                           o_hit, o_translated_address);
                    fails++;
                end else begin
                    got_exp = expected_xlat.pop_front();
                    if (o_hit !== got_exp.hit) begin
                        $error("hit: expected %0d, actual %0d", got_exp.hit, o_hit);
                        fails++;
                    end
                    if (o_translated_address !== got_exp.xlat) begin
                        $error("translated_address: expected %h, actual %h",
                               got_exp.xlat, o_translated_address);
                        fails++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_xlat.push_back(translate_op({i_mode, i_virtual_address,
                                                      i_physical_address}));
                ops_taken++;
            end
        end
    end

    // driver: hold until transfer, then advance or idle
    always @(negedge i_clk) begin
        t_op nxt;
        if (i_rst_n && (!i_in_valid || in_xfer)) begin
            if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
                nxt = pending_ops.pop_front();
                i_in_valid <= 1'b1;
                i_mode <= nxt.mode;
                i_virtual_address <= nxt.va;
                i_physical_address <= nxt.pa;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, one long hold-off
    always @(negedge i_clk) begin
        if (squeeze && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 34);
        end
    end

    task automatic push_op(logic [1:0] mode, t_addr va, t_addr pa);
        pending_ops.push_back({mode, va, pa});
        ops_queued++;
    endtask

    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (ops_taken != ops_queued || expected_xlat.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(logic [APB_DATA_W-1:0] data, logic expect_on);
        apb_write(TP_ADDR, data);
        @(negedge i_clk);
        psel <= 1'b1;
        paddr <= TP_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[0] !== expect_on) begin
            $error("table_present: expected %0d, actual %0d", expect_on, prdata[0]);
            fails++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_random(int count);
        int    pick;
        t_addr va;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) begin
            addr_pool[k] = $urandom;
        end
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            va = addr_pool[$urandom_range(POOL_SIZE - 1)];
            if (pick < 45) begin
                push_op(MODE_LOOKUP, va, $urandom);
            end else if (pick < 77) begin
                push_op(MODE_INSERT, va, $urandom);
            end else if (pick < 81) begin
                push_op(MODE_FLUSH, $urandom, $urandom);
            end else if (pick < 85) begin
                push_op(MODE_UNUSED, $urandom, $urandom);
            end else if (pick < 93) begin
                push_op(MODE_LOOKUP, $urandom, $urandom);
            end else begin
                push_op(MODE_INSERT, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no table: lookups miss, inserts still land
        configure(32'd0, 1'b0);
        push_op(MODE_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        push_op(MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        push_op(MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        push_op(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // table present: hits, duplicate mapping, flush, unused mode
        configure(32'd1, 1'b1);
        push_op(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        push_op(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_op(MODE_INSERT, 32'h0000_0000, 32'h1234_5678);
        push_op(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        push_op(MODE_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000);
        push_op(MODE_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        push_op(MODE_LOOKUP, 32'hA5A5_A5A5, 32'h0000_0000);
        push_op(MODE_FLUSH,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_op(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        push_op(MODE_LOOKUP, 32'hA5A5_A5A5, 32'h0000_0000);
        push_op(MODE_INSERT, 32'h0000_0001, 32'h0000_0002);
        push_op(MODE_LOOKUP, 32'h0000_0001, 32'h0000_0000);
        push_op(MODE_UNUSED, 32'h0000_0000, 32'h0000_0000);
        push_op(MODE_LOOKUP, 32'h0000_0001, 32'hFFFF_FFFF);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 3) begin
                configure(32'd0, 1'b0);
            end else if (ph == 4) begin
                configure(32'd1, 1'b1);
                apb_write(UNUSED_ADDR, 32'd0);
                configure(32'hFFFF_FFFF, 1'b1);
            end else begin
                configure(32'd1, 1'b1);
            end
            calm = (ph == 1);
            if (ph == 2) begin
                squeeze = 1'b1;
            end
            push_random(165);
            drain();
        end

        repeat (ENTRY_COUNT + 8) @(posedge i_clk);
        if (fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/lt_pkg.sv
hw/rtl/lt_cell.sv
hw/rtl/lru_tlb.sv
sim/lru_tlb_tb.sv
